/* sv/frame_duration_resolver_assert.svh */
// Assertion macros for the frame duration resolver.
// Each use expands to one labeled concurrent assertion on clk / rst_n.
`ifndef FRAME_DURATION_RESOLVER_ASSERT_SVH
`define FRAME_DURATION_RESOLVER_ASSERT_SVH

// Same-cycle implication
`define FDR_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("frame duration resolver: check failed");

// Next-cycle implication
`define FDR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("frame duration resolver: check failed");

`endif

/* sv/fdr_pkg.sv */
`timescale 1ns / 1ps

package fdr_pkg;

  // History window
  localparam int HistDepth = 8;
  localparam int IdxW      = (HistDepth > 1) ? $clog2(HistDepth) : 1;
  localparam int CntW      = $clog2(HistDepth + 1);

  // Stream widths
  localparam int InDataW  = 256;
  localparam int InUserW  = 2;
  localparam int OutDataW = 264;

  // Value limits
  localparam logic signed [63:0] MaxS64     = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] MaxS64Div4 = 64'sh1FFF_FFFF_FFFF_FFFF;

  // Duration source codes
  localparam logic [1:0] SRC_DELTA = 2'd0;
  localparam logic [1:0] SRC_PRED  = 2'd1;
  localparam logic [1:0] SRC_META  = 2'd2;
  localparam logic [1:0] SRC_FALLB = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_PRED,
    ST_CHKD,
    ST_CHKM,
    ST_DECIDE
  } state_t;

  // Controller -> datapath
  typedef struct packed {
    logic load;
    logic restart;
    logic scan;
    logic pred;
    logic chkd;
    logic chkm;
    logic commit;
  } cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic hist_empty;
    logic scan_last;
    logic out_free;
  } status_t;

endpackage

/* sv/frame_duration_resolver.sv */
`timescale 1ns / 1ps
// Frame duration resolver: picks one duration per video frame.
// Input stream (in_*): one transaction per frame or restart. in_tuser[0] set
// marks a restart, which clears the history and the source memory in the
// accepting cycle and gives no result. Otherwise the frame is resolved from
// the timestamp delta, the history median, the metadata or the frame field.
// Output stream (out_*): one transaction per frame with the chosen duration,
// the source codes and the intermediate values.
// An accepted frame passes through the median scan over the n (0..8) history
// entries, which ranks one entry per cycle against all others, then through
// prediction, delta check, metadata check and the decision step. The block
// accepts nothing new until the decision has committed the frame's result.
// Reset (rst_n low, synchronous) empties the history, forgets the previous
// source and drops any pending result.
// A stalled receiver: the finished result sits in the output register while
// the next frame is accepted and worked on; that frame then waits at its last
// step until the register is free.
module frame_duration_resolver import fdr_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  // cur_stamp, prev_stamp, meta_duration, field_duration
  input  logic [InDataW-1:0]  in_tdata,
  // req_type, has_prev_stamp
  input  logic [InUserW-1:0]  in_tuser,
  output logic                out_tvalid,
  input  logic                out_tready,
  // predicted, meta_echo, stamp_delta, resolved, chosen_source,
  // had_prior_source, prior_source, src_switched, zero fill
  output logic [OutDataW-1:0] out_tdata
);

`include "frame_duration_resolver_assert.svh"

  cmd_t    cmd;
  status_t status;

  fdr_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .req_restart (in_tuser[0]),
    .in_tready   (in_tready),
    .status      (status),
    .cmd         (cmd)
  );

  fdr_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .status     (status),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // An accepted frame transaction takes the block out of the ready state
  `FDR_ASSERT_NEXT(a_frame_busy, in_tvalid && in_tready && !in_tuser[0], !in_tready)
  // Resolved duration is always positive
  `FDR_ASSERT_NOW(a_res_pos, out_tvalid, out_tdata[252:190] != 63'd0)
  // Change flag agrees with the source fields
  `FDR_ASSERT_NOW(a_chg_flag, out_tvalid,
    out_tdata[258] == (!out_tdata[255] || (out_tdata[254:253] != out_tdata[257:256])))

endmodule

/* sv/fdr_ctrl.sv */
`timescale 1ns / 1ps

module fdr_ctrl import fdr_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_tvalid,
  input  logic    req_restart,
  output logic    in_tready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid && !req_restart) begin
          state_nxt = status.hist_empty ? ST_PRED : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (status.scan_last) state_nxt = ST_PRED;
      end
      ST_PRED:   state_nxt = ST_CHKD;
      ST_CHKD:   state_nxt = ST_CHKM;
      ST_CHKM:   state_nxt = ST_DECIDE;
      ST_DECIDE: begin
        if (status.out_free) state_nxt = ST_IDLE;
      end
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready   = 1'b1;
        cmd.load    = in_tvalid && !req_restart;
        cmd.restart = in_tvalid && req_restart;
      end
      ST_SCAN:   cmd.scan   = 1'b1;
      ST_PRED:   cmd.pred   = 1'b1;
      ST_CHKD:   cmd.chkd   = 1'b1;
      ST_CHKM:   cmd.chkm   = 1'b1;
      ST_DECIDE: cmd.commit = status.out_free;
      default: ;
    endcase
  end

endmodule

/* sv/fdr_dp.sv */
`timescale 1ns / 1ps

module fdr_dp import fdr_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  cmd_t                cmd,
  output status_t             status,
  input  logic [InDataW-1:0]  in_tdata,
  input  logic [InUserW-1:0]  in_tuser,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [OutDataW-1:0] out_tdata
);

  // Plausibility of d against anchor a
  function automatic logic plausible(input logic signed [63:0] d,
                                     input logic signed [63:0] a);
    logic signed [63:0] lo;
    logic signed [63:0] hi;
    lo = a >>> 2;
    if (lo < 64'sd1) lo = 64'sd1;
    hi = (a > MaxS64Div4) ? MaxS64 : (a <<< 2);
    if (d <= 64'sd0) begin
      return 1'b0;
    end else if (a <= 64'sd0) begin
      return 1'b1;
    end else begin
      return (d >= lo) && (d <= hi);
    end
  endfunction

  // History and source memory
  logic [62:0]     hist_r [HistDepth];
  logic [CntW-1:0] cnt_r;
  logic [IdxW-1:0] slot_r;
  logic            have_last_r;
  logic [1:0]      last_src_r;

  // Latched frame
  logic signed [63:0] meta_r, field_r;
  logic [62:0]        delta_r;

  // Median scan
  logic [IdxW-1:0] idx_r;
  logic [62:0]     mid_lo_r, mid_hi_r, pred_r;
  logic            delta_ok_r, meta_ok_r;

  // Result register
  logic        out_valid_r;
  logic [62:0] o_pred_r, o_delta_r, o_res_r;
  logic [63:0] o_meta_r;
  logic [1:0]  o_src_r, o_prior_r;
  logic        o_had_r, o_chg_r;

  // Timestamp delta, 65-bit so overflow shows up
  logic signed [63:0] cur_s, prev_s;
  logic [64:0]        diff;
  logic [62:0]        delta_new;

  assign cur_s  = in_tdata[63:0];
  assign prev_s = in_tdata[127:64];
  assign diff   = {cur_s[63], cur_s} - {prev_s[63], prev_s};

  always_comb begin
    delta_new = '0;
    if (in_tuser[1] && (diff[64:63] == 2'b00) && (diff[62:0] != '0)) begin
      delta_new = diff[62:0];
    end
  end

  // Rank of the current candidate among the valid entries
  logic [62:0]     cand;
  logic [CntW-1:0] rank;
  logic [CntW-1:0] half;
  logic [CntW-1:0] cnt_m1;

  assign cand   = hist_r[idx_r];
  assign half   = cnt_r >> 1;
  assign cnt_m1 = cnt_r - CntW'(1);

  always_comb begin
    rank = '0;
    for (int j = 0; j < HistDepth; j++) begin
      if ((CntW'(j) < cnt_r) &&
          ((hist_r[j] < cand) || ((hist_r[j] == cand) && (IdxW'(j) < idx_r)))) begin
        rank = rank + CntW'(1);
      end
    end
  end

  assign status.hist_empty = (cnt_r == '0);
  assign status.scan_last  = (CntW'(idx_r) == cnt_m1);
  assign status.out_free   = !out_valid_r || out_tready;

  // Median of the scanned entries
  logic [62:0] pred_new;
  always_comb begin
    if (cnt_r == '0) begin
      pred_new = '0;
    end else if (cnt_r[0]) begin
      pred_new = mid_hi_r;
    end else begin
      pred_new = (mid_lo_r >> 1) + (mid_hi_r >> 1) + 63'(mid_lo_r[0] & mid_hi_r[0]);
    end
  end

  // Source selection
  logic [62:0] res_sel;
  logic [1:0]  src_sel;
  always_comb begin
    priority if (delta_ok_r) begin
      res_sel = delta_r;
      src_sel = SRC_DELTA;
    end else if (pred_r != '0) begin
      res_sel = pred_r;
      src_sel = SRC_PRED;
    end else if (meta_ok_r) begin
      res_sel = meta_r[62:0];
      src_sel = SRC_META;
    end else begin
      res_sel = (field_r > 64'sd0) ? field_r[62:0] : 63'd1;
      src_sel = SRC_FALLB;
    end
  end

  // Payload path
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      meta_r  <= in_tdata[191:128];
      field_r <= in_tdata[255:192];
      delta_r <= delta_new;
    end
    if (cmd.scan) begin
      if (rank == half) mid_hi_r <= cand;
      if (!cnt_r[0] && (rank == half - CntW'(1))) mid_lo_r <= cand;
    end
    if (cmd.pred) pred_r <= pred_new;
    if (cmd.chkd) begin
      delta_ok_r <= (delta_r != '0) &&
                    plausible({1'b0, delta_r}, (pred_r != '0) ? {1'b0, pred_r} : meta_r);
    end
    if (cmd.chkm) begin
      meta_ok_r <= (field_r > 64'sd0) && plausible(meta_r, field_r);
    end
    if (cmd.commit) begin
      o_pred_r  <= pred_r;
      o_meta_r  <= meta_r;
      o_delta_r <= delta_r;
      o_res_r   <= res_sel;
      o_src_r   <= src_sel;
      o_had_r   <= have_last_r;
      o_prior_r <= last_src_r;
      o_chg_r   <= !have_last_r || (src_sel != last_src_r);
      if (src_sel != SRC_FALLB) hist_r[slot_r] <= res_sel;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      slot_r      <= '0;
      have_last_r <= 1'b0;
      last_src_r  <= SRC_FALLB;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.commit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (cmd.load) idx_r <= '0;
      if (cmd.scan) idx_r <= idx_r + IdxW'(1);
      if (cmd.restart) begin
        cnt_r       <= '0;
        slot_r      <= '0;
        have_last_r <= 1'b0;
        last_src_r  <= SRC_FALLB;
      end
      if (cmd.commit) begin
        have_last_r <= 1'b1;
        last_src_r  <= src_sel;
        if (src_sel != SRC_FALLB) begin
          slot_r <= (slot_r == IdxW'(HistDepth - 1)) ? '0 : slot_r + IdxW'(1);
          if (cnt_r != CntW'(HistDepth)) cnt_r <= cnt_r + CntW'(1);
        end
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, o_chg_r, o_prior_r, o_had_r, o_src_r,
                       o_res_r, o_delta_r, o_meta_r, o_pred_r};

endmodule
